@@ design/lkvc_pkg.sv @@
// Shared types, constants and helpers of the LRU key-value cache.
package lkvc_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic [DATA_W-1:0]        hit_total;
    logic [DATA_W-1:0]        miss_total;
    logic [DATA_W-1:0]        eviction_total;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [RANK_W-1:0] rank;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_cmd_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] c);
    sat_inc = (&c) ? c : c + DATA_W'(1);
  endfunction

endpackage

@@ design/lru_key_value_cache_core.sv @@
// Top level of the LRU key-value cache: configuration, entry memory and result register.
//
//  Channel  Direction  Handshake                 Payload
//  in       sink       in_valid_i / in_ready_o   in_req_i (req_t)
//  out      source     out_valid_o / out_ready_i out_rsp_o (rsp_t)
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_capacity_i
//
// A get that misses makes a single pass over the entry memory; every other request makes
// two passes over the entry memory, a scan and an update, one read and one write per cycle.
// Reset clears all entries at once through their valid bits; no sweep is needed.
// A finished result waits in the output register while the next request is accepted;
// the sequencer holds its following result until that register is free.
module lru_key_value_cache_core import lkvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_capacity_i
);

  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  rsp_t             out_q;
  mem_cmd_t         mem_cmd;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t           rd_entry;
  logic             res_valid;
  logic             res_ready;
  rsp_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  lkvc_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (mem_cmd.re),
    .raddr_i (mem_cmd.raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_cmd.we),
    .waddr_i (mem_cmd.waddr),
    .wdata_i (mem_cmd.wdata)
  );

  assign rd_entry = mem_rdata;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .capacity_i  (cap_q),
    .mem_cmd_o   (mem_cmd),
    .mem_rdata_i (rd_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ design/lkvc_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
module lkvc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/lkvc_ctrl.sv @@
// Sequencer that scans the entry memory, decides the outcome and, unless a get misses, rewrites the entries and ranks.
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  input  logic [CAP_W-1:0] capacity_i,
  output mem_cmd_t         mem_cmd_o,
  input  entry_t           mem_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output rsp_t             res_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ENTRIES);
  localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(MAX_ENTRIES);

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   rvalid_q, rvalid_d;
  logic [IDX_W-1:0]       ridx_q, ridx_d;
  logic [MAX_ENTRIES-1:0] vld_q, vld_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic [DATA_W-1:0]      hit_cnt_q, hit_cnt_d;
  logic [DATA_W-1:0]      miss_cnt_q, miss_cnt_d;
  logic [DATA_W-1:0]      evc_cnt_q, evc_cnt_d;
  logic                   hit_q, hit_d;
  logic                   vic_found_q, vic_found_d;
  logic                   free_found_q, free_found_d;
  logic                   ins_q, ins_d;

  req_t                   req_q, req_d;
  logic [IDX_W-1:0]       hit_idx_q, hit_idx_d;
  logic [RANK_W-1:0]      hit_rank_q, hit_rank_d;
  logic [DATA_W-1:0]      hit_val_q, hit_val_d;
  logic [IDX_W-1:0]       vic_idx_q, vic_idx_d;
  logic [RANK_W-1:0]      vic_rank_q, vic_rank_d;
  logic [IDX_W-1:0]       free_idx_q, free_idx_d;
  logic [IDX_W-1:0]       tgt_idx_q, tgt_idx_d;
  logic                   found_q, found_d;
  logic [DATA_W-1:0]      read_val_q, read_val_d;
  logic                   evicted_q, evicted_d;

  logic                   issue;
  logic                   cur_vld;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   evict;
  logic [IDX_W-1:0]       slot;
  entry_t                 wdata;
  logic                   we;

  assign issue   = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (cnt_q != CNT_END);
  assign cur_vld = vld_q[ridx_q];
  assign cap_ext = CMP_W'(capacity_i);
  assign eff_cap = (cap_ext == '0) ? CMP_W'(1) : ((cap_ext > CAP_MAX) ? CAP_MAX : cap_ext);
  assign evict   = !hit_q && (req_q.kind == KIND_PUT) && vic_found_q &&
                   (CMP_W'(occ_q) >= eff_cap);
  assign slot    = (evict && (!free_found_q || (vic_idx_q < free_idx_q))) ? vic_idx_q
                                                                          : free_idx_q;

  always_comb begin
    wdata = mem_rdata_i;
    we    = 1'b0;
    if ((state_q == ST_UPDATE) && rvalid_q) begin
      if (ridx_q == tgt_idx_q) begin
        we         = 1'b1;
        wdata.rank = '0;
        if (req_q.kind == KIND_PUT) begin
          wdata.value = req_q.value;
        end
        if (ins_q) begin
          wdata.key = req_q.key;
        end
      end else if (cur_vld) begin
        we = 1'b1;
        if (ins_q || (mem_rdata_i.rank < hit_rank_q)) begin
          wdata.rank = mem_rdata_i.rank + RANK_W'(1);
        end
      end
    end
  end

  assign mem_cmd_o.re    = issue;
  assign mem_cmd_o.raddr = cnt_q[IDX_W-1:0];
  assign mem_cmd_o.we    = we;
  assign mem_cmd_o.waddr = ridx_q;
  assign mem_cmd_o.wdata = wdata;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rvalid_d     = issue;
    ridx_d       = cnt_q[IDX_W-1:0];
    vld_d        = vld_q;
    occ_d        = occ_q;
    hit_cnt_d    = hit_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    evc_cnt_d    = evc_cnt_q;
    hit_d        = hit_q;
    vic_found_d  = vic_found_q;
    free_found_d = free_found_q;
    ins_d        = ins_q;
    req_d        = req_q;
    hit_idx_d    = hit_idx_q;
    hit_rank_d   = hit_rank_q;
    hit_val_d    = hit_val_q;
    vic_idx_d    = vic_idx_q;
    vic_rank_d   = vic_rank_q;
    free_idx_d   = free_idx_q;
    tgt_idx_d    = tgt_idx_q;
    found_d      = found_q;
    read_val_d   = read_val_q;
    evicted_d    = evicted_q;

    if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          cnt_d        = '0;
          hit_d        = 1'b0;
          vic_found_d  = 1'b0;
          free_found_d = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rvalid_q) begin
          if (cur_vld && (mem_rdata_i.key == req_q.key) && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = ridx_q;
            hit_rank_d = mem_rdata_i.rank;
            hit_val_d  = mem_rdata_i.value;
          end
          if (cur_vld && (!vic_found_q || (mem_rdata_i.rank > vic_rank_q))) begin
            vic_found_d = 1'b1;
            vic_idx_d   = ridx_q;
            vic_rank_d  = mem_rdata_i.rank;
          end
          if (!cur_vld && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = ridx_q;
          end
        end else if (cnt_q == CNT_END) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_d      = '0;
        found_d    = hit_q;
        read_val_d = ((req_q.kind == KIND_GET) && hit_q) ? hit_val_q : '0;
        evicted_d  = evict;
        tgt_idx_d  = hit_idx_q;
        ins_d      = 1'b0;
        state_d    = ST_UPDATE;
        if (req_q.kind == KIND_GET) begin
          if (hit_q) begin
            hit_cnt_d = sat_inc(hit_cnt_q);
          end else begin
            miss_cnt_d = sat_inc(miss_cnt_q);
            state_d    = ST_DONE;
          end
        end else if (!hit_q) begin
          if (evict) begin
            vld_d[vic_idx_q] = 1'b0;
            evc_cnt_d        = sat_inc(evc_cnt_q);
          end
          vld_d[slot] = 1'b1;
          occ_d       = occ_q - CNT_W'(evict) + CNT_W'(1);
          tgt_idx_d   = slot;
          ins_d       = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (!rvalid_q && (cnt_q == CNT_END)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rvalid_q     <= 1'b0;
      vld_q        <= '0;
      occ_q        <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      evc_cnt_q    <= '0;
      hit_q        <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      ins_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rvalid_q     <= rvalid_d;
      vld_q        <= vld_d;
      occ_q        <= occ_d;
      hit_cnt_q    <= hit_cnt_d;
      miss_cnt_q   <= miss_cnt_d;
      evc_cnt_q    <= evc_cnt_d;
      hit_q        <= hit_d;
      vic_found_q  <= vic_found_d;
      free_found_q <= free_found_d;
      ins_q        <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ridx_q     <= ridx_d;
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    hit_val_q  <= hit_val_d;
    vic_idx_q  <= vic_idx_d;
    vic_rank_q <= vic_rank_d;
    free_idx_q <= free_idx_d;
    tgt_idx_q  <= tgt_idx_d;
    found_q    <= found_d;
    read_val_q <= read_val_d;
    evicted_q  <= evicted_d;
  end

  assign in_ready_o           = (state_q == ST_IDLE);
  assign res_valid_o          = (state_q == ST_DONE);
  assign res_o.found          = found_q;
  assign res_o.read_value     = read_val_q;
  assign res_o.evicted        = evicted_q;
  assign res_o.hit_total      = hit_cnt_q;
  assign res_o.miss_total     = miss_cnt_q;
  assign res_o.eviction_total = evc_cnt_q;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(vld_q)))
    else $error("Occupancy disagrees with the valid bits.");

  a_write_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_cmd_o.we |-> (state_q == ST_UPDATE))
    else $error("Entry memory written outside the update pass.");

  a_scan_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> ((cnt_q == CNT_END) && !rvalid_q))
    else $error("Decision taken before the scan finished.");

  a_evict_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !(evicted_q && found_q))
    else $error("A request both hit and evicted.");

endmodule
